### rtl/bounded_array_store_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded array store
// Short forms for clocked implication checks with a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_STORE_ASSERT_SVH
`define BOUNDED_ARRAY_STORE_ASSERT_SVH

// Same-cycle implication: when the antecedent holds, so does the consequent.
`define BAS_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent follows.
`define BAS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bas_pkg.sv
// ----------------------------------------------------------------------------
// bas_pkg
// Sizes, codes and controller/datapath interface types of the bounded
// array store.
// ----------------------------------------------------------------------------
package bas_pkg;

   // Storage depth and the widths that follow from it.
   localparam int DEPTH = 256;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Fixed field widths of the request and response.
   localparam int CMD_W       = 3;
   localparam int POS_W       = 9;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 9;

   // Width used to compare a position against the count.
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [CMD_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_GET    = 3'd2,
      OP_SET    = 3'd3,
      OP_INSERT = 3'd4,
      OP_REMOVE = 3'd5
   } bas_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } bas_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CAPTURE,
      S_SHIFT,
      S_FINISH
   } bas_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           latch;       // capture the accepted request
      logic           st_load;     // load the result status
      bas_status_type st_val;
      logic           push_wr;     // write at the count, count up
      logic           set_wr;      // write at the position
      logic           rd_top;      // read the last entry, count down
      logic           rd_pos;      // read at the position
      logic           capture;     // take the read word as the result
      logic           shift_init;  // load the shift cursor
      logic           shift_step;  // one move of the shift pipeline
      logic           place;       // write at the position, count up
      logic           dec;         // count down
      logic           finish;      // load the response register
   } bas_ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic             full;
      logic             empty;
      logic             pos_lt_count;
      logic             pos_gt_count;
      logic             shift_done;
      logic             rsp_free;
   } bas_stat_type;

endpackage

### rtl/bounded_array_store.sv
// Push, set and failed requests go from decode straight to the finish state;
// pop and get pass a capture state, reading through the registered RAM port.
// Insert and remove pass a shift state (an insert at the count moves no entry);
// the single RAM write port moves one entry per cycle. One request is in flight;
// the next is accepted the cycle after its response is loaded, even if that waits.
// Reset is synchronous and empties the store; entry contents are not cleared.
// ----------------------------------------------------------------------------
// bounded_array_store
// Ordered store of signed words with push, pop, get, set, insert and remove,
// returning a status, the word read and the entry count for each request.
// ----------------------------------------------------------------------------
module bounded_array_store (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bas_pkg::CMD_W-1:0]         req_cmd,
   input  logic [bas_pkg::POS_W-1:0]         req_position,
   input  logic signed [bas_pkg::DATA_W-1:0] req_data_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bas_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [bas_pkg::DATA_W-1:0] rsp_data_out,
   output logic [bas_pkg::COUNT_OUT_W-1:0]   rsp_entry_count
);

   bas_pkg::bas_ctl_type  ctl;
   bas_pkg::bas_stat_type stat;

   // Request sequencer.
   bas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Storage and response path.
   bas_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_position    (req_position),
      .req_data_in     (req_data_in),
      .ctl             (ctl),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

### rtl/bas_ctrl.sv
// ----------------------------------------------------------------------------
// bas_ctrl
// Sequencer of the bounded array store: decodes a request, runs the read,
// write or shift steps and hands the result to the response register.
// ----------------------------------------------------------------------------
module bas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bas_pkg::bas_stat_type stat,
   output bas_pkg::bas_ctl_type  ctl
);

   bas_pkg::bas_state_type state_ff;
   bas_pkg::bas_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bas_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = (state_ff == bas_pkg::S_IDLE);
      unique case (state_ff)
         bas_pkg::S_IDLE: begin
            if (req_valid) begin
               ctl.latch = 1'b1;
               state_in  = bas_pkg::S_DECODE;
            end
         end
         bas_pkg::S_DECODE: begin
            ctl.st_load = 1'b1;
            ctl.st_val  = bas_pkg::ST_RANGE;
            state_in    = bas_pkg::S_FINISH;
            unique case (stat.op)
               bas_pkg::OP_PUSH: begin
                  if (stat.full) begin
                     ctl.st_val = bas_pkg::ST_FULL;
                  end else begin
                     ctl.st_val  = bas_pkg::ST_OK;
                     ctl.push_wr = 1'b1;
                  end
               end
               bas_pkg::OP_POP: begin
                  if (!stat.empty) begin
                     ctl.st_val = bas_pkg::ST_OK;
                     ctl.rd_top = 1'b1;
                     state_in   = bas_pkg::S_CAPTURE;
                  end
               end
               bas_pkg::OP_GET: begin
                  if (stat.pos_lt_count) begin
                     ctl.st_val = bas_pkg::ST_OK;
                     ctl.rd_pos = 1'b1;
                     state_in   = bas_pkg::S_CAPTURE;
                  end
               end
               bas_pkg::OP_SET: begin
                  if (stat.pos_lt_count) begin
                     ctl.st_val = bas_pkg::ST_OK;
                     ctl.set_wr = 1'b1;
                  end
               end
               bas_pkg::OP_INSERT: begin
                  // The range check comes before the full check.
                  if (stat.pos_gt_count) begin
                     ctl.st_val = bas_pkg::ST_RANGE;
                  end else if (stat.full) begin
                     ctl.st_val = bas_pkg::ST_FULL;
                  end else begin
                     ctl.st_val     = bas_pkg::ST_OK;
                     ctl.shift_init = 1'b1;
                     state_in       = bas_pkg::S_SHIFT;
                  end
               end
               bas_pkg::OP_REMOVE: begin
                  if (stat.pos_lt_count) begin
                     ctl.st_val     = bas_pkg::ST_OK;
                     ctl.shift_init = 1'b1;
                     state_in       = bas_pkg::S_SHIFT;
                  end
               end
               default: begin
                  // Unused codes report a range status and change nothing.
               end
            endcase
         end
         bas_pkg::S_CAPTURE: begin
            ctl.capture = 1'b1;
            state_in    = bas_pkg::S_FINISH;
         end
         bas_pkg::S_SHIFT: begin
            ctl.shift_step = 1'b1;
            if (stat.shift_done) begin
               if (stat.op == bas_pkg::OP_INSERT) begin
                  ctl.place = 1'b1;
               end else begin
                  ctl.dec = 1'b1;
               end
               state_in = bas_pkg::S_FINISH;
            end
         end
         bas_pkg::S_FINISH: begin
            if (stat.rsp_free) begin
               ctl.finish = 1'b1;
               state_in   = bas_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bas_pkg::S_IDLE;
         end
      endcase
   end

endmodule

### rtl/bas_datapath.sv
// ----------------------------------------------------------------------------
// bas_datapath
// Entry RAM, count, shift pipeline and response register of the bounded
// array store.
// ----------------------------------------------------------------------------
module bas_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [bas_pkg::CMD_W-1:0]             req_cmd,
   input  logic [bas_pkg::POS_W-1:0]             req_position,
   input  logic signed [bas_pkg::DATA_W-1:0]     req_data_in,
   input  bas_pkg::bas_ctl_type                  ctl,
   output bas_pkg::bas_stat_type                 stat,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bas_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [bas_pkg::DATA_W-1:0]     rsp_data_out,
   output logic [bas_pkg::COUNT_OUT_W-1:0]       rsp_entry_count
);

   // Entry RAM: one write port, one registered read port.
   logic [bas_pkg::DATA_W-1:0] mem [bas_pkg::DEPTH];

   logic [bas_pkg::CMD_W-1:0]       op_ff;
   logic [bas_pkg::POS_W-1:0]       pos_ff;
   logic [bas_pkg::DATA_W-1:0]      din_ff;
   logic [bas_pkg::CNT_W-1:0]       count_ff, count_in;
   bas_pkg::bas_status_type         st_ff;
   logic [bas_pkg::DATA_W-1:0]      dout_ff, dout_in;
   logic [bas_pkg::CNT_W-1:0]       cursor_ff, cursor_in;
   logic                            mv_valid_ff, mv_valid_in;
   logic                            mv_first_ff, mv_first_in;
   logic [bas_pkg::IDX_W-1:0]       mv_waddr_ff, mv_waddr_in;
   logic [bas_pkg::DATA_W-1:0]      rdata_ff;
   logic                            rsp_valid_ff;
   logic [bas_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic [bas_pkg::DATA_W-1:0]      rsp_data_ff;
   logic [bas_pkg::COUNT_OUT_W-1:0] rsp_count_ff;

   logic [bas_pkg::CMP_W-1:0]  pos_x, cnt_x, cur_x;
   logic [bas_pkg::CNT_W-1:0]  cur_dec, cur_inc, cnt_dec;
   logic                       shift_up;
   logic                       rd_go;
   logic [bas_pkg::IDX_W-1:0]  rd_addr;
   logic                       we;
   logic [bas_pkg::IDX_W-1:0]  waddr;
   logic [bas_pkg::DATA_W-1:0] wdata;
   logic                       rsp_free;

   // Common compares and cursor arithmetic.
   always_comb begin
      pos_x    = bas_pkg::CMP_W'(pos_ff);
      cnt_x    = bas_pkg::CMP_W'(count_ff);
      cur_x    = bas_pkg::CMP_W'(cursor_ff);
      cur_dec  = cursor_ff - 1'b1;
      cur_inc  = cursor_ff + 1'b1;
      cnt_dec  = count_ff - 1'b1;
      shift_up = (op_ff == bas_pkg::OP_INSERT);
      // Insert walks down from the count to the position; remove walks up.
      rd_go    = shift_up ? (cur_x > pos_x) : (cursor_ff < count_ff);
      rsp_free = !rsp_valid_ff || rsp_ready;
   end

   // RAM read address.
   always_comb begin
      rd_addr = pos_x[bas_pkg::IDX_W-1:0];
      if (ctl.rd_top) begin
         rd_addr = cnt_dec[bas_pkg::IDX_W-1:0];
      end else if (ctl.shift_step) begin
         rd_addr = shift_up ? cur_dec[bas_pkg::IDX_W-1:0]
                            : cursor_ff[bas_pkg::IDX_W-1:0];
      end else if (ctl.rd_pos) begin
         rd_addr = pos_x[bas_pkg::IDX_W-1:0];
      end
   end

   // RAM write port: a pending shift move, a push, or a write at the position.
   always_comb begin
      we    = 1'b0;
      waddr = pos_x[bas_pkg::IDX_W-1:0];
      wdata = din_ff;
      if (mv_valid_ff && !mv_first_ff) begin
         we    = 1'b1;
         waddr = mv_waddr_ff;
         wdata = rdata_ff;
      end else if (ctl.push_wr) begin
         we    = 1'b1;
         waddr = count_ff[bas_pkg::IDX_W-1:0];
      end else if (ctl.set_wr || ctl.place) begin
         we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Next values of the count, the cursor, the shift stage and the result.
   always_comb begin
      count_in = count_ff;
      if (ctl.push_wr || ctl.place) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.rd_top || ctl.dec) begin
         count_in = cnt_dec;
      end

      cursor_in = cursor_ff;
      if (ctl.shift_init) begin
         cursor_in = shift_up ? count_ff : pos_x[bas_pkg::CNT_W-1:0];
      end else if (ctl.shift_step && rd_go) begin
         cursor_in = shift_up ? cur_dec : cur_inc;
      end

      // A read issued now is written back one entry away next cycle; the
      // first read of a remove is the removed word itself.
      mv_valid_in = ctl.shift_step && rd_go;
      mv_first_in = !shift_up && (cursor_ff == pos_x[bas_pkg::CNT_W-1:0]);
      mv_waddr_in = shift_up ? cursor_ff[bas_pkg::IDX_W-1:0]
                             : cur_dec[bas_pkg::IDX_W-1:0];

      dout_in = dout_ff;
      if (ctl.latch) begin
         dout_in = '0;
      end else if (ctl.capture || (mv_valid_ff && mv_first_ff)) begin
         dout_in = rdata_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mv_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         mv_valid_ff <= mv_valid_in;
         if (ctl.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         op_ff  <= req_cmd;
         pos_ff <= req_position;
         din_ff <= req_data_in;
      end
      if (ctl.st_load) begin
         st_ff <= ctl.st_val;
      end
      dout_ff     <= dout_in;
      cursor_ff   <= cursor_in;
      mv_first_ff <= mv_first_in;
      mv_waddr_ff <= mv_waddr_in;
      if (ctl.finish) begin
         rsp_status_ff <= st_ff;
         rsp_data_ff   <= dout_ff;
         rsp_count_ff  <= cnt_x[bas_pkg::COUNT_OUT_W-1:0];
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.op           = op_ff;
      stat.full         = (count_ff == bas_pkg::CNT_W'(bas_pkg::DEPTH));
      stat.empty        = (count_ff == '0);
      stat.pos_lt_count = (pos_x < cnt_x);
      stat.pos_gt_count = (pos_x > cnt_x);
      stat.shift_done   = !rd_go && !mv_valid_ff;
      stat.rsp_free     = rsp_free;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

### rtl/bas_checker.sv
// ----------------------------------------------------------------------------
// bas_checker
// Port-level checks of the bounded array store, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_array_store_assert.svh"

module bas_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [bas_pkg::STATUS_W-1:0]      rsp_status,
   input logic signed [bas_pkg::DATA_W-1:0] rsp_data_out,
   input logic [bas_pkg::COUNT_OUT_W-1:0]   rsp_entry_count
);

   // Only one request is worked on at a time.
   `BAS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request accepted while busy")

   // A failed request returns no data.
   `BAS_ASSERT_IMPL(a_error_no_data, clock, reset, rsp_valid && (rsp_status != 2'(bas_pkg::ST_OK)), rsp_data_out == '0, "data on a failed request")

   // A full status is only reported when the store holds every entry.
   `BAS_ASSERT_IMPL(a_full_count, clock, reset, rsp_valid && (rsp_status == 2'(bas_pkg::ST_FULL)), rsp_entry_count == bas_pkg::COUNT_OUT_W'(bas_pkg::DEPTH), "full status below depth")

   // A stalled response holds its data.
   `BAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_out), "response changed while stalled")

endmodule

bind bounded_array_store bas_checker u_bas_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_data_out    (rsp_data_out),
   .rsp_entry_count (rsp_entry_count)
);
